// ===== design/espg_pkg.sv =====
// package for the ellipse spiral set-point generator
// constants, request codes and controller/datapath command types; no dependencies
package espg_pkg;

  localparam int FRAC_BITS_DEF    = 24;
  localparam int CORDIC_STEPS_DEF = 24;

  localparam logic [1:0] REQ_TICK    = 2'd0;
  localparam logic [1:0] REQ_ENABLE  = 2'd1;
  localparam logic [1:0] REQ_DISABLE = 2'd2;

  localparam logic [2:0] REG_CX   = 3'd0;
  localparam logic [2:0] REG_CY   = 3'd1;
  localparam logic [2:0] REG_A0   = 3'd2;
  localparam logic [2:0] REG_B0   = 3'd3;
  localparam logic [2:0] REG_INIT = 3'd4;
  localparam logic [2:0] REG_INCR = 3'd5;
  localparam logic [2:0] REG_GROW = 3'd6;
  localparam logic [2:0] REG_SHR  = 3'd7;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // atan(2^-i) in q0.32 turns, truncated
  function automatic logic [31:0] atan_turns(input logic [4:0] i);
    logic [31:0] t;
    unique case (i)
      5'd0:  t = 32'd536870912;
      5'd1:  t = 32'd316933405;
      5'd2:  t = 32'd167458907;
      5'd3:  t = 32'd85004756;
      5'd4:  t = 32'd42667330;
      5'd5:  t = 32'd21354465;
      5'd6:  t = 32'd10679838;
      5'd7:  t = 32'd5340245;
      5'd8:  t = 32'd2670163;
      5'd9:  t = 32'd1335086;
      5'd10: t = 32'd667543;
      5'd11: t = 32'd333771;
      5'd12: t = 32'd166885;
      5'd13: t = 32'd83442;
      5'd14: t = 32'd41721;
      5'd15: t = 32'd20860;
      5'd16: t = 32'd10430;
      5'd17: t = 32'd5215;
      5'd18: t = 32'd2607;
      5'd19: t = 32'd1303;
      5'd20: t = 32'd651;
      5'd21: t = 32'd325;
      5'd22: t = 32'd162;
      5'd23: t = 32'd81;
      5'd24: t = 32'd40;
      5'd25: t = 32'd20;
      5'd26: t = 32'd10;
      5'd27: t = 32'd5;
      5'd28: t = 32'd2;
      5'd29: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  typedef struct packed {
    logic enable;      // restart run
    logic disable_run;
    logic idle_tick;   // pass actual through
    logic first;       // first tick of a run
    logic trig_start;  // launch cordic and output sum
    logic div_start;   // launch divisions for turn advance
    logic commit;      // apply turn advance and load outputs
  } espg_cmd_t;

  typedef struct packed {
    logic active;      // running and turn within path
    logic first_tick;
    logic trig_done;
    logic div_done;
  } espg_sts_t;

endpackage

// ===== design/espg_ctrl.sv =====
// controller for the set-point generator: sequences cordic, divisions and commit
// depends on espg_pkg
module espg_ctrl import espg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  output logic       out_valid,
  input  logic       out_stall,
  input  espg_sts_t  sts,
  output espg_cmd_t  cmd
);

  typedef enum logic [2:0] {S_IDLE, S_TRIG, S_DIV, S_OUT} state_t;
  state_t state_r;
  logic   out_valid_r;
  logic   out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign out_valid = out_valid_r;

  logic take;
  assign take = in_valid && !in_stall;

  always_comb begin
    cmd = '0;
    if (take && state_r == S_IDLE) begin
      unique case (in_req_type)
        REQ_ENABLE:  cmd.enable = 1'b1;
        REQ_DISABLE: cmd.disable_run = 1'b1;
        REQ_TICK: begin
          if (!sts.active)         cmd.idle_tick = 1'b1;
          else if (sts.first_tick) cmd.first = 1'b1;
          else                     cmd.trig_start = 1'b1;
        end
        default: ;
      endcase
    end
    if (state_r == S_TRIG && sts.trig_done) cmd.div_start = 1'b1;
    if (state_r == S_DIV && sts.div_done) cmd.commit = 1'b1;
  end

  // result held while stalled, raised by an idle or first tick or after commit
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.idle_tick || cmd.first || state_r == S_OUT) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: if (cmd.trig_start) state_r <= S_TRIG;
        S_TRIG: if (sts.trig_done) state_r <= S_DIV;
        S_DIV:  if (sts.div_done) state_r <= S_OUT;
        S_OUT:  state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/espg_cordic.sv =====
// iterative rotation-mode cordic, one micro-rotation a cycle
// depends on espg_pkg
module espg_cordic import espg_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [31:0]        phase,
  output logic               done,
  output logic signed [31:0] cos_q,
  output logic signed [31:0] sin_q
);

  localparam int IW = $clog2(CORDIC_STEPS + 1);

  logic signed [33:0] x_r, y_r;
  logic signed [32:0] z_r;
  logic [1:0]         q_r;
  logic [IW-1:0]      i_r;
  logic               busy_r, done_r;
  logic [31:0]        f;

  assign f = phase << (32 - FRAC_BITS);

  logic signed [33:0] dx, dy;
  logic signed [32:0] da;
  assign dx = y_r >>> i_r;
  assign dy = x_r >>> i_r;
  assign da = $signed({1'b0, atan_turns(5'(i_r))});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
        x_r    <= CORDIC_GAIN;
        y_r    <= '0;
        z_r    <= $signed({3'b000, f[29:0]});
        q_r    <= f[31:30];
      end else if (busy_r) begin
        if (!z_r[32]) begin
          x_r <= x_r - dx; y_r <= y_r + dy; z_r <= z_r - da;
        end else begin
          x_r <= x_r + dx; y_r <= y_r - dy; z_r <= z_r + da;
        end
        if (i_r == IW'(CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        i_r <= i_r + 1'b1;
      end
    end
  end

  localparam logic signed [33:0] ONE = 34'sd1073741824;
  logic signed [33:0] xc, yc;
  always_comb begin
    xc = (x_r > ONE) ? ONE : ((x_r < -ONE) ? -ONE : x_r);
    yc = (y_r > ONE) ? ONE : ((y_r < -ONE) ? -ONE : y_r);
    unique case (q_r)
      2'd0: begin cos_q = 32'(xc);  sin_q = 32'(yc);  end
      2'd1: begin cos_q = 32'(-yc); sin_q = 32'(xc);  end
      2'd2: begin cos_q = 32'(-xc); sin_q = 32'(-yc); end
      default: begin cos_q = 32'(yc); sin_q = 32'(-xc); end
    endcase
  end
  assign done = done_r;

endmodule

// ===== design/espg_div.sv =====
// restoring divider, one quotient bit a cycle, 40 bit dividend by 31 bit divisor
// no dependencies
module espg_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [39:0] dividend,
  input  logic [30:0] divisor,
  output logic        done,
  output logic [39:0] quotient
);

  logic [39:0] q_r;
  logic [31:0] rem_r;
  logic [30:0] d_r;
  logic [5:0]  n_r;
  logic        busy_r, done_r;
  logic [32:0] trial;

  assign trial = {rem_r, q_r[39]} - {2'b00, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r <= dividend; rem_r <= '0; d_r <= divisor; n_r <= '0; busy_r <= 1'b1;
      end else if (busy_r) begin
        if (!trial[32]) begin
          rem_r <= trial[31:0];
          q_r   <= {q_r[38:0], 1'b1};
        end else begin
          rem_r <= {rem_r[30:0], q_r[39]};
          q_r   <= {q_r[38:0], 1'b0};
        end
        n_r <= n_r + 1'b1;
        if (n_r == 6'd39) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quotient = q_r;

endmodule

// ===== design/espg_dp.sv =====
// datapath: configuration, run state, cordic, output sum, jump check and turn advance
// depends on espg_pkg, espg_cordic, espg_div
module espg_dp import espg_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic signed [31:0] in_actual_x,
  input  logic signed [31:0] in_actual_y,
  input  espg_cmd_t          cmd,
  output espg_sts_t          sts,
  output logic signed [31:0] out_set_x,
  output logic signed [31:0] out_set_y,
  output logic               out_finished,
  output logic               out_jump_fault
);

  localparam logic [31:0]        ONE  = 32'(1) << FRAC_BITS;
  localparam logic [31:0]        QTR  = ONE >> 2;
  localparam logic signed [33:0] LIM  = 34'((64'(1) << FRAC_BITS) / 100);

  logic [31:0] cx_r, cy_r;
  logic [30:0] a0_r, b0_r;
  logic [23:0] incr_r;
  logic [4:0]  grow_r, shr_r;

  logic        running_r, first_r, done_r;
  logic [31:0] phase_r;
  logic [24:0] step_r;
  logic [6:0]  tc_r;
  logic [30:0] axa_r, axb_r;
  logic [31:0] prev_x_r, prev_y_r;
  logic [31:0] ox_r, oy_r;
  logic        fault_r;

  logic [5:0]  sum_t;
  assign sum_t = {1'b0, grow_r} + {1'b0, shr_r};

  assign sts.active     = running_r && ({1'b0, tc_r} <= {2'b00, sum_t} + 8'd1);
  assign sts.first_tick = first_r;

  // cordic
  logic signed [31:0] cq, sq;
  logic               trig_done;
  espg_cordic #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(cmd.trig_start), .phase(phase_r),
    .done(trig_done), .cos_q(cq), .sin_q(sq)
  );

  // products registered, then the sum and jump check
  logic signed [63:0] px_r, py_r;
  logic               prod_v_r;
  always_ff @(posedge clk) begin
    px_r <= $signed({33'd0, axa_r}) * cq;
    py_r <= $signed({33'd0, axb_r}) * sq;
  end
  always_ff @(posedge clk) begin
    if (!rst_n) prod_v_r <= 1'b0;
    else        prod_v_r <= trig_done;
  end
  assign sts.trig_done = prod_v_r;

  function automatic logic [31:0] sat(input logic signed [34:0] v);
    if (v > 35'sd2147483647) return 32'h7fffffff;
    if (v < -35'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  logic signed [34:0] sumx, sumy;
  logic [31:0]        sx, sy;
  logic signed [33:0] ddx, ddy;
  logic               jump;
  always_comb begin
    sumx = $signed({{3{cx_r[31]}}, cx_r}) + 35'((px_r + 64'sd536870912) >>> 30);
    sumy = $signed({{3{cy_r[31]}}, cy_r}) + 35'((py_r + 64'sd536870912) >>> 30);
    sx   = sat(sumx);
    sy   = sat(sumy);
    ddx  = $signed({{2{sx[31]}}, sx}) - $signed({{2{prev_x_r[31]}}, prev_x_r});
    ddy  = $signed({{2{sy[31]}}, sy}) - $signed({{2{prev_y_r[31]}}, prev_y_r});
    jump = ddx > LIM || -ddx > LIM || ddy > LIM || -ddy > LIM;
  end

  logic [31:0] sx_r, sy_r;
  logic        jump_r;
  always_ff @(posedge clk) begin
    if (prod_v_r) begin
      sx_r <= sx; sy_r <= sy; jump_r <= jump;
    end
  end

  // divisions: b0/(g+1-tc) and a0*k/sum
  logic [39:0] qb, qa;
  logic        db, da;
  logic [6:0]  bden;
  logic [6:0]  k_sel;
  logic [39:0] a0k;
  logic [7:0]  g1;
  assign g1   = {3'b000, grow_r} + 8'd1;
  assign bden = 7'(g1 - {1'b0, tc_r});
  // which shrink index the turn advance at commit uses
  logic [31:0] pn;
  assign pn = phase_r + {7'd0, step_r};
  logic [38:0] cturn;
  assign cturn = {32'd0, tc_r} << FRAC_BITS;
  logic lo_case;
  assign lo_case = ({7'd0, pn} > cturn + {7'd0, QTR}) ? 1'b0 : 1'b1;
  assign k_sel = (({1'b0, tc_r} == g1) && lo_case) ? tc_r - 7'd1 : tc_r;
  assign a0k   = {9'd0, a0_r} * {33'd0, k_sel};

  espg_div u_divb (.clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend({9'd0, b0_r}), .divisor({24'd0, bden}), .done(db), .quotient(qb));
  espg_div u_diva (.clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(a0k), .divisor({25'd0, sum_t}), .done(da), .quotient(qa));
  assign sts.div_done = db && da;

  logic [30:0] shrunk;
  always_comb begin
    if (sum_t == 6'd0 || qa >= {9'd0, a0_r}) shrunk = '0;
    else shrunk = a0_r - qa[30:0];
  end

  logic [25:0] up;
  logic [24:0] step_up, step_dn;
  assign up      = {1'b0, step_r} + {2'b00, incr_r};
  assign step_up = up[25] ? 25'h1ffffff : up[24:0];
  assign step_dn = (step_r > {1'b0, incr_r}) ? step_r - {1'b0, incr_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; a0_r <= '0; b0_r <= '0;
      incr_r <= '0; grow_r <= 5'd1; shr_r <= 5'd1;
      running_r <= 1'b0; first_r <= 1'b1; done_r <= 1'b0;
      phase_r <= QTR; step_r <= '0; tc_r <= 7'd1;
      axa_r <= '0; axb_r <= '0; prev_x_r <= '0; prev_y_r <= '0;
      fault_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_CX:   cx_r   <= cfg_data;
          REG_CY:   cy_r   <= cfg_data;
          REG_A0:   a0_r   <= cfg_data[30:0];
          REG_B0:   b0_r   <= cfg_data[30:0];
          REG_INIT: step_r <= {1'b0, cfg_data[23:0]};
          REG_INCR: incr_r <= cfg_data[23:0];
          REG_GROW: grow_r <= cfg_data[4:0];
          REG_SHR:  shr_r  <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (cmd.enable) begin
        running_r <= 1'b1; tc_r <= 7'd1; phase_r <= QTR;
        first_r <= 1'b1; done_r <= 1'b0;
      end
      if (cmd.disable_run) running_r <= 1'b0;
      if (cmd.idle_tick) begin
        ox_r <= in_actual_x; oy_r <= in_actual_y;
        prev_x_r <= in_actual_x; prev_y_r <= in_actual_y; fault_r <= 1'b0;
      end
      if (cmd.first) begin
        ox_r <= cx_r; oy_r <= cy_r; prev_x_r <= cx_r; prev_y_r <= cy_r;
        phase_r <= phase_r + {7'd0, step_r};
        axa_r <= a0_r; axb_r <= '0; first_r <= 1'b0; fault_r <= 1'b0;
      end
      if (cmd.commit) begin
        if (jump_r) begin
          running_r <= 1'b0; ox_r <= prev_x_r; oy_r <= prev_y_r; fault_r <= 1'b1;
        end else begin
          ox_r <= sx_r; oy_r <= sy_r; prev_x_r <= sx_r; prev_y_r <= sy_r;
          fault_r <= 1'b0;
          phase_r <= pn;
          if ({1'b0, tc_r} <= {3'b000, grow_r}) begin
            if ({7'd0, pn} >= cturn) begin
              axa_r <= a0_r; axb_r <= qb[30:0]; tc_r <= tc_r + 7'd1; step_r <= step_up;
            end
          end else if ({1'b0, tc_r} == g1) begin
            axb_r <= b0_r;
            if ({7'd0, pn} + {6'd0, QTR, 1'b0} + {7'd0, QTR} <= cturn) begin
              axa_r <= a0_r;
            end else if (lo_case) begin
              axa_r <= shrunk;
            end else begin
              axa_r <= shrunk; tc_r <= tc_r + 7'd1; step_r <= step_dn;
            end
          end else if ({1'b0, tc_r} <= {2'b00, sum_t}) begin
            if ({7'd0, pn} >= cturn + {7'd0, QTR}) begin
              axa_r <= shrunk; axb_r <= b0_r; tc_r <= tc_r + 7'd1; step_r <= step_dn;
            end
          end else if ({7'd0, pn} <= cturn) begin
            axa_r <= '0; axb_r <= b0_r;
          end else begin
            axa_r <= '0; axb_r <= '0; done_r <= 1'b1; running_r <= 1'b0;
            tc_r <= tc_r + 7'd1;
          end
        end
      end
    end
  end

  assign out_set_x      = ox_r;
  assign out_set_y      = oy_r;
  assign out_finished   = done_r;
  assign out_jump_fault = fault_r;

endmodule

// ===== design/ellipse_spiral_setpoint_generator_core.sv =====
// Ellipse spiral set-point generator. One request is taken at a time. Enable and
// disable requests give no result; an idle tick or the first tick of a run gives its
// result in the cycle after it is taken. A running tick runs the cordic, then two
// bit-serial dividers for the axis updates, then commits its result. Configuration
// is written through the cfg port, which is always ready.
// depends on espg_pkg, espg_ctrl, espg_dp
module ellipse_spiral_setpoint_generator_core import espg_pkg::*; #(
  parameter int FRAC_BITS    = FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_req_type,
  input  logic signed [31:0] in_actual_x,
  input  logic signed [31:0] in_actual_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_set_x,
  output logic signed [31:0] out_set_y,
  output logic               out_finished,
  output logic               out_jump_fault
);

  espg_cmd_t cmd;
  espg_sts_t sts;

  assign cfg_ready = 1'b1;

  espg_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_req_type(in_req_type), .out_valid(out_valid), .out_stall(out_stall),
    .sts(sts), .cmd(cmd)
  );

  espg_dp #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_actual_x(in_actual_x), .in_actual_y(in_actual_y),
    .cmd(cmd), .sts(sts), .out_set_x(out_set_x), .out_set_y(out_set_y),
    .out_finished(out_finished), .out_jump_fault(out_jump_fault)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.enable, cmd.disable_run, cmd.idle_tick, cmd.first,
                cmd.trig_start}) <= 1)
    else $error("more than one request command");

  a_commit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> in_stall)
    else $error("commit while input open");

  a_out_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> ##1 out_valid)
    else $error("no result after commit");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for ellipse_spiral_setpoint_generator_core
// predicts each set point from its own cordic and path model, checks results in order
// depends on espg_pkg and the core rtl
`timescale 1ns / 1ps

module tb_top;
  import espg_pkg::*;

  typedef struct {
    logic [1:0]  req;
    logic [31:0] ax;
    logic [31:0] ay;
  } request_t;

  typedef struct {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        fin;
    logic        fault;
  } setpoint_t;

  localparam longint unsigned MASK32   = 64'hFFFF_FFFF;
  localparam longint unsigned STEP_TOP = 64'h1FF_FFFF;
  localparam longint unsigned ONE_TURN = 64'd1 << 24;
  localparam longint unsigned QUARTER  = ONE_TURN >> 2;
  localparam longint          GAIN     = 64'sd652032874;
  localparam longint          PI_Q60   = 64'sh3243F6A8885A308D;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_stall;
  logic [1:0] in_req_type;
  logic signed [31:0] in_actual_x, in_actual_y;
  logic out_valid, out_stall;
  logic signed [31:0] out_set_x, out_set_y;
  logic out_finished, out_jump_fault;

  ellipse_spiral_setpoint_generator_core dut (.*);

  request_t  pending_reqs[$];
  setpoint_t expected_pts[$];
  int errors = 0, n_results = 0, n_faults = 0, n_finished = 0;
  logic in_fire;
  logic calm = 0;

  // configuration copy
  longint unsigned c_cx, c_cy, c_a0, c_b0, c_init, c_incr, c_grow, c_shr;
  // path state
  bit running, first_tick, done_flag;
  longint unsigned phase, pstep, turn, axis_a, axis_b, prev_x, prev_y;
  longint atan_tab[32];

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint sext32(longint unsigned v);
    return longint'({{32{v[31]}}, v[31:0]});
  endfunction

  function automatic longint unsigned sat32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return longint'(v) & MASK32;
  endfunction

  function automatic longint series_atan(int i);
    longint rad = 0, term;
    longint unsigned num;
    if (i == 0) return 64'sd1 << 29;
    for (int k = 0; i * (2 * k + 1) < 60; k++) begin
      term = longint'((64'd1 << 60) >> (i * (2 * k + 1))) / (2 * k + 1);
      rad += (k & 1) ? -term : term;
    end
    num = (longint'(rad) >> 28) << 31;
    return longint'(num / (longint'(PI_Q60) >> 28));
  endfunction

  task automatic cordic(input longint unsigned ph, output longint c, output longint s);
    longint unsigned f;
    longint x, y, z, dx, dy, t;
    int q;
    f = (ph << 8) & MASK32;
    q = int'(f >> 30);
    z = longint'(f & 64'h3FFF_FFFF);
    x = GAIN;
    y = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tab[i];
      end else begin
        x += dx; y -= dy; z += atan_tab[i];
      end
    end
    if (x > (64'sd1 << 30)) x = 64'sd1 << 30;
    if (x < -(64'sd1 << 30)) x = -(64'sd1 << 30);
    if (y > (64'sd1 << 30)) y = 64'sd1 << 30;
    if (y < -(64'sd1 << 30)) y = -(64'sd1 << 30);
    case (q)
      1: begin t = x; x = -y; y = t; end
      2: begin x = -x; y = -y; end
      3: begin t = x; x = y; y = -t; end
      default: ;
    endcase
    c = x;
    s = y;
  endtask

  function automatic longint unsigned shrunk_axis(longint unsigned k);
    longint unsigned total, d;
    total = c_grow + c_shr;
    if (total == 0) return 0;
    d = (c_a0 * k) / total;
    return (d >= c_a0) ? 0 : c_a0 - d;
  endfunction

  task automatic step_fall();
    pstep = (pstep > c_incr) ? pstep - c_incr : 0;
  endtask

  task automatic next_turn_stage();
    longint unsigned cturn, total;
    cturn = turn * ONE_TURN;
    total = c_grow + c_shr;
    if (turn <= c_grow) begin
      if (phase >= cturn) begin
        axis_a = c_a0;
        axis_b = c_b0 / (c_grow + 1 - turn);
        turn = (turn + 1) & 7'h7F;
        pstep += c_incr;
        if (pstep > STEP_TOP) pstep = STEP_TOP;
      end
    end else if (turn == c_grow + 1) begin
      axis_b = c_b0;
      if (phase + 3 * QUARTER <= cturn) axis_a = c_a0;
      else if (phase <= cturn + QUARTER) axis_a = shrunk_axis(turn - 1);
      else begin
        axis_a = shrunk_axis(turn);
        turn = (turn + 1) & 7'h7F;
        step_fall();
      end
    end else if (turn <= total) begin
      if (phase >= cturn + QUARTER) begin
        axis_a = shrunk_axis(turn);
        axis_b = c_b0;
        turn = (turn + 1) & 7'h7F;
        step_fall();
      end
    end else if (phase <= cturn) begin
      axis_a = 0;
      axis_b = c_b0;
    end else begin
      axis_a = 0;
      axis_b = 0;
      done_flag = 1;
      running = 0;
      turn = (turn + 1) & 7'h7F;
    end
  endtask

  task automatic predict_setpoint(input request_t r);
    setpoint_t e;
    longint unsigned sx, sy;
    longint c, s, dx, dy, lim;
    bit fault = 0;
    lim = longint'(ONE_TURN / 100);
    case (r.req)
      REQ_ENABLE: begin
        running = 1; turn = 1; phase = QUARTER; first_tick = 1; done_flag = 0;
        return;
      end
      REQ_DISABLE: begin
        running = 0;
        return;
      end
      REQ_TICK: ;
      default: return;
    endcase
    if (running && turn <= c_grow + c_shr + 1) begin
      if (first_tick) begin
        sx = c_cx; sy = c_cy;
        phase = (phase + pstep) & MASK32;
        axis_a = c_a0; axis_b = 0; first_tick = 0;
      end else begin
        cordic(phase, c, s);
        sx = sat32(sext32(c_cx) + ((longint'(axis_a) * c + (64'sd1 << 29)) >>> 30));
        sy = sat32(sext32(c_cy) + ((longint'(axis_b) * s + (64'sd1 << 29)) >>> 30));
        dx = sext32(sx) - sext32(prev_x);
        dy = sext32(sy) - sext32(prev_y);
        if (dx > lim || -dx > lim || dy > lim || -dy > lim) begin
          running = 0; sx = prev_x; sy = prev_y; fault = 1;
        end else begin
          phase = (phase + pstep) & MASK32;
          next_turn_stage();
        end
      end
    end else begin
      sx = r.ax; sy = r.ay;
    end
    prev_x = sx; prev_y = sy;
    e.sx = sx[31:0]; e.sy = sy[31:0]; e.fin = done_flag; e.fault = fault;
    expected_pts.push_back(e);
  endtask

  // sender
  always @(posedge clk) begin
    in_fire <= in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall)
      predict_setpoint('{in_req_type, in_actual_x, in_actual_y});
  end

  always @(negedge clk) begin
    request_t r;
    if (!rst_n) begin
      in_valid <= 0;
    end else if (!in_valid || in_fire) begin
      if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
        r = pending_reqs.pop_front();
        in_req_type <= r.req;
        in_actual_x <= r.ax;
        in_actual_y <= r.ay;
        in_valid <= 1;
      end else begin
        in_valid <= 0;
      end
    end
    out_stall <= !calm && $urandom_range(99) < 31;
  end

  // result checker
  always @(posedge clk) begin
    setpoint_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (out_jump_fault) n_faults++;
      if (out_finished) n_finished++;
      if (expected_pts.size() == 0) begin
        $error("set point with no request waiting");
        errors++;
      end else begin
        e = expected_pts.pop_front();
        if (out_set_x !== e.sx) begin
          $error("set_x expected %h actual %h", e.sx, out_set_x); errors++;
        end
        if (out_set_y !== e.sy) begin
          $error("set_y expected %h actual %h", e.sy, out_set_y); errors++;
        end
        if (out_finished !== e.fin) begin
          $error("finished expected %b actual %b", e.fin, out_finished); errors++;
        end
        if (out_jump_fault !== e.fault) begin
          $error("jump_fault expected %b actual %b", e.fault, out_jump_fault); errors++;
        end
      end
    end
  end

  task automatic add_req(logic [1:0] req, logic [31:0] ax = $urandom, logic [31:0] ay = $urandom);
    pending_reqs.push_back('{req, ax, ay});
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_CX:   c_cx = val;
      REG_CY:   c_cy = val;
      REG_A0:   c_a0 = val[30:0];
      REG_B0:   c_b0 = val[30:0];
      REG_INIT: begin c_init = val[23:0]; pstep = c_init; end
      REG_INCR: c_incr = val[23:0];
      REG_GROW: c_grow = val[4:0];
      REG_SHR:  c_shr = val[4:0];
    endcase
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic drain();
    wait (pending_reqs.size() == 0 && !in_valid && expected_pts.size() == 0);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] cx, logic [31:0] cy, logic [31:0] a0, logic [31:0] b0,
                           logic [31:0] init, logic [31:0] incr, logic [31:0] g, logic [31:0] s);
    write_reg(REG_CX, cx); write_reg(REG_CY, cy);
    write_reg(REG_A0, a0); write_reg(REG_B0, b0);
    write_reg(REG_INIT, init); write_reg(REG_INCR, incr);
    write_reg(REG_GROW, g); write_reg(REG_SHR, s);
  endtask

  task automatic random_phase(int n, bit wild);
    int roll;
    if (wild)
      write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom);
    else
      write_all($urandom, $urandom, $urandom_range(1 << 17), $urandom_range(1 << 17),
                $urandom_range(1 << 22, 1 << 20), $urandom_range(1 << 18),
                $urandom_range(3, 1), $urandom_range(3, 1));
    add_req(REQ_ENABLE);
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 86) add_req(REQ_TICK);
      else if (roll < 91) add_req(REQ_ENABLE);
      else if (roll < 95) add_req(REQ_DISABLE);
      else add_req(2'd3);
    end
    drain();
  endtask

  initial begin
    for (int i = 0; i < 32; i++) atan_tab[i] = series_atan(i);
    c_cx = 0; c_cy = 0; c_a0 = 0; c_b0 = 0; c_init = 0; c_incr = 0; c_grow = 1; c_shr = 1;
    running = 0; first_tick = 1; done_flag = 0; phase = QUARTER; pstep = 0; turn = 1;
    axis_a = 0; axis_b = 0; prev_x = 0; prev_y = 0;
    rst_n = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; in_req_type = REQ_TICK; in_actual_x = 0; in_actual_y = 0; out_stall = 0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n = 1;

    // idle pass-through at the extremes, unused request code, reset config run
    add_req(REQ_TICK, 32'h7FFF_FFFF, 32'h8000_0000);
    add_req(REQ_TICK, 32'h8000_0000, 32'h7FFF_FFFF);
    add_req(2'd3);
    add_req(REQ_ENABLE);
    add_req(REQ_TICK); add_req(REQ_TICK); add_req(REQ_TICK);
    drain();
    // saturating sums, largest step and increment, zero turn sum
    write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFF_FFFF,
              32'hFF_FFFF, 0, 0);
    add_req(REQ_ENABLE); add_req(REQ_TICK); add_req(REQ_TICK); add_req(REQ_TICK);
    add_req(REQ_DISABLE); add_req(REQ_TICK, 0, 32'hFFFF_FFFF);
    drain();
    // grow turns with no shrink turns and tiny axes
    write_all(0, 0, 32'h1000, 32'h1000, 32'h40_0000, 32'h10_0000, 31, 0);
    add_req(REQ_ENABLE);
    repeat (6) add_req(REQ_TICK);
    drain();

    calm = 1;
    random_phase(60, 0);
    calm = 0;
    for (int p = 0; p < 6; p++) random_phase(60, p == 3);
    random_phase(30, 1);
    drain();
    $display("%0d set points checked, %0d jump faults, %0d with path finished",
             n_results, n_faults, n_finished);
    if (errors == 0)
      $display("PASS ellipse_spiral_setpoint_generator_core");
    else
      $display("FAIL ellipse_spiral_setpoint_generator_core");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL ellipse_spiral_setpoint_generator_core");
    $finish;
  end

endmodule
